// ===== hdl/lhb_pkg.sv =====
// Package for the LED heartbeat and breathing controller: register map, reset values, widths.
package lhb_pkg;

  // Configuration port widths
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // Default elapsed-timer width
  localparam int TIMER_WIDTH_DEF = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ON_TIME         = 3'd0,
    REG_REST_TIME       = 3'd1,
    REG_LEVEL_HOLD      = 3'd2,
    REG_RAMP_STEP       = 3'd3,
    REG_START_LEVEL     = 3'd4,
    REG_DEBOUNCE_TICKS  = 3'd5,
    REG_LED_ON_LEVEL    = 3'd6,
    REG_BUTTON_ON_LEVEL = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [15:0] RST_ON_TIME         = 16'd80;
  localparam logic [15:0] RST_REST_TIME       = 16'd840;
  localparam logic [15:0] RST_LEVEL_HOLD      = 16'd50;
  localparam logic [7:0]  RST_RAMP_STEP       = 8'd10;
  localparam logic [7:0]  RST_START_LEVEL     = 8'd5;
  localparam logic [15:0] RST_DEBOUNCE_TICKS  = 16'd100;
  localparam logic        RST_LED_ON_LEVEL    = 1'b0;
  localparam logic        RST_BUTTON_ON_LEVEL = 1'b0;

  // Duty ceiling and last heartbeat phase
  localparam logic [8:0] DUTY_FULL  = 9'd255;
  localparam logic [1:0] PHASE_LAST = 2'd3;

endpackage

// ===== hdl/led_heartbeat_breathing_controller.sv =====
// Top level: LED heartbeat / breathing pattern controller with button debounce.
//
//   channel  direction  handshake            payload
//   in       in         in_valid / in_stall  button_level
//   out      out        out_valid/out_stall  led_level, pwm_active, pwm_duty, heartbeat_mode
//   cfg      in         cfg_write            cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each tick is resolved combinationally from the
// state registers into the result register; a result appears in the cycle after acceptance.
// Reset is synchronous and loads the register defaults and the idle pattern state.
// in_stall is raised only while a result is held in the output register under out_stall.
module led_heartbeat_breathing_controller
  import lhb_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   button_level,
  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   led_level,
  output logic                   pwm_active,
  output logic [7:0]             pwm_duty,
  output logic                   heartbeat_mode,
  // configuration writes
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // compare width covers both timers and 16-bit period registers
  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  // configuration registers
  logic [15:0] on_time, rest_time, level_hold, debounce_ticks;
  logic [7:0]  ramp_step, start_level;
  logic        led_on_level, button_on_level;

  // pattern state
  logic                   mode_heartbeat, mode_heartbeat_next;
  logic [7:0]             duty_level, duty_level_next;
  logic [8:0]             ramp_delta, ramp_delta_next;
  logic [TIMER_WIDTH-1:0] level_elapsed, level_elapsed_next;
  logic [1:0]             beat_phase, beat_phase_next;
  logic [TIMER_WIDTH-1:0] beat_elapsed, beat_elapsed_next;
  logic [15:0]            beat_wait, beat_wait_next;
  logic                   debounce_busy, debounce_busy_next;
  logic [TIMER_WIDTH-1:0] debounce_elapsed, debounce_elapsed_next;
  logic                   button_stable, button_stable_next;
  logic                   pwm_on, pwm_on_next;
  logic                   led_pin, led_pin_next;

  logic                   in_accept;
  logic [TIMER_WIDTH-1:0] lvl_inc, beat_inc, deb_inc;
  logic [9:0]             duty_sum;
  logic                   toggle;

  // item handshake: accept whenever the result register is free or draining
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      on_time         <= RST_ON_TIME;
      rest_time       <= RST_REST_TIME;
      level_hold      <= RST_LEVEL_HOLD;
      ramp_step       <= RST_RAMP_STEP;
      start_level     <= RST_START_LEVEL;
      debounce_ticks  <= RST_DEBOUNCE_TICKS;
      led_on_level    <= RST_LED_ON_LEVEL;
      button_on_level <= RST_BUTTON_ON_LEVEL;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ON_TIME:         on_time         <= cfg_data[15:0];
        REG_REST_TIME:       rest_time       <= cfg_data[15:0];
        REG_LEVEL_HOLD:      level_hold      <= cfg_data[15:0];
        REG_RAMP_STEP:       ramp_step       <= cfg_data[7:0];
        REG_START_LEVEL:     start_level     <= cfg_data[7:0];
        REG_DEBOUNCE_TICKS:  debounce_ticks  <= cfg_data[15:0];
        REG_LED_ON_LEVEL:    led_on_level    <= cfg_data[0];
        REG_BUTTON_ON_LEVEL: button_on_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturating elapsed counters
  assign lvl_inc  = (&level_elapsed)    ? level_elapsed    : level_elapsed + TIMER_WIDTH'(1);
  assign beat_inc = (&beat_elapsed)     ? beat_elapsed     : beat_elapsed + TIMER_WIDTH'(1);
  assign deb_inc  = (&debounce_elapsed) ? debounce_elapsed
                                        : debounce_elapsed + TIMER_WIDTH'(1);

  // duty plus signed ramp delta, two's complement in 10 bits
  assign duty_sum = {2'b00, duty_level} + {ramp_delta[8], ramp_delta};

  // one tick: timers, active pattern, then debounce and mode toggle
  always_comb begin
    mode_heartbeat_next   = mode_heartbeat;
    duty_level_next       = duty_level;
    ramp_delta_next       = ramp_delta;
    level_elapsed_next    = lvl_inc;
    beat_phase_next       = beat_phase;
    beat_elapsed_next     = beat_inc;
    beat_wait_next        = beat_wait;
    debounce_busy_next    = debounce_busy;
    debounce_elapsed_next = deb_inc;
    button_stable_next    = button_stable;
    pwm_on_next           = pwm_on;
    led_pin_next          = led_pin;
    toggle                = 1'b0;

    // heartbeat: lit in odd phases, dark in even ones
    if (mode_heartbeat) begin
      if (CMP_W'(beat_inc) > CMP_W'(beat_wait)) begin
        led_pin_next      = beat_phase[0] ? ~led_on_level : led_on_level;
        beat_elapsed_next = '0;
        if (beat_phase == PHASE_LAST) begin
          beat_wait_next  = rest_time;
          beat_phase_next = '0;
        end else begin
          beat_wait_next  = on_time;
          beat_phase_next = beat_phase + 2'd1;
        end
      end
    end else begin
      // pulse: triangle ramp, restart at start level when it bottoms out
      if (CMP_W'(lvl_inc) > CMP_W'(level_hold)) begin
        if (duty_sum[9] || (duty_sum == 10'd0)) begin
          duty_level_next = start_level;
          ramp_delta_next = {1'b0, ramp_step};
        end else if (duty_sum[8:0] >= DUTY_FULL) begin
          duty_level_next = 8'hFF;
          ramp_delta_next = 9'd0 - {1'b0, ramp_step};
        end else begin
          duty_level_next = duty_sum[7:0];
        end
        pwm_on_next        = 1'b1;
        level_elapsed_next = '0;
      end
    end

    // debounce; a bounce back to the stable level leaves the count running
    if (button_level != button_stable) begin
      if (!debounce_busy) begin
        debounce_busy_next    = 1'b1;
        debounce_elapsed_next = '0;
      end else if (CMP_W'(deb_inc) > CMP_W'(debounce_ticks)) begin
        debounce_busy_next = 1'b0;
        toggle             = (button_stable == button_on_level);
        button_stable_next = button_level;
      end
    end

    // mode toggle on release: LED dark, chosen pattern restarts
    if (toggle) begin
      pwm_on_next         = 1'b0;
      led_pin_next        = ~led_on_level;
      mode_heartbeat_next = ~mode_heartbeat;
      if (!mode_heartbeat) begin
        beat_elapsed_next = '0;
        beat_phase_next   = '0;
        beat_wait_next    = rest_time;
      end else begin
        level_elapsed_next = '1;
        ramp_delta_next    = {1'b0, start_level};
        duty_level_next    = '0;
      end
    end
  end

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_heartbeat   <= 1'b1;
      duty_level       <= '0;
      ramp_delta       <= {1'b0, RST_RAMP_STEP};
      level_elapsed    <= '0;
      beat_phase       <= '0;
      beat_elapsed     <= '0;
      beat_wait        <= '0;
      debounce_busy    <= 1'b0;
      debounce_elapsed <= '0;
      button_stable    <= ~RST_BUTTON_ON_LEVEL;
      pwm_on           <= 1'b0;
      led_pin          <= ~RST_LED_ON_LEVEL;
    end else if (in_accept) begin
      mode_heartbeat   <= mode_heartbeat_next;
      duty_level       <= duty_level_next;
      ramp_delta       <= ramp_delta_next;
      level_elapsed    <= level_elapsed_next;
      beat_phase       <= beat_phase_next;
      beat_elapsed     <= beat_elapsed_next;
      beat_wait        <= beat_wait_next;
      debounce_busy    <= debounce_busy_next;
      debounce_elapsed <= debounce_elapsed_next;
      button_stable    <= button_stable_next;
      pwm_on           <= pwm_on_next;
      led_pin          <= led_pin_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      led_level      <= pwm_on_next ? 1'b0 : led_pin_next;
      pwm_active     <= pwm_on_next;
      pwm_duty       <= pwm_on_next ? duty_level_next : 8'd0;
      heartbeat_mode <= mode_heartbeat_next;
    end
  end

`ifndef NO_ASSERTIONS
  // PWM drive and digital drive are exclusive
  a_pwm_led_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && pwm_active |-> !led_level)
    else $error("led_level high while PWM active");

  // duty reads zero when PWM is idle
  a_duty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pwm_active |-> pwm_duty == 8'd0)
    else $error("pwm_duty nonzero while PWM idle");

  // PWM only runs in pulse mode
  a_pwm_pulse_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && pwm_active |-> !heartbeat_mode)
    else $error("PWM active in heartbeat mode");

  // an accepted item always produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item without result");
`endif

endmodule

// ===== tb/led_heartbeat_breathing_controller_tb.sv =====
// Testbench for the LED heartbeat and breathing controller: tick stimulus, shadow model, checks.
`timescale 1ns / 100ps

module led_heartbeat_breathing_controller_tb;
  import lhb_pkg::*;

  localparam int TW = TIMER_WIDTH_DEF;
  localparam logic [TW-1:0] TIMER_FULL = '1;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD = 200;

  // one result item: what the LED pin and mode outputs should show
  typedef struct packed {
    logic       led;
    logic       pwm;
    logic [7:0] duty;
    logic       beat;
  } led_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   button_level = 1'b1;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   led_level;
  logic                   pwm_active;
  logic [7:0]             pwm_duty;
  logic                   heartbeat_mode;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  led_heartbeat_breathing_controller uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .button_level   (button_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .led_level      (led_level),
    .pwm_active     (pwm_active),
    .pwm_duty       (pwm_duty),
    .heartbeat_mode (heartbeat_mode),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // shadow copy of the registers
  logic [15:0] sh_on_time, sh_rest_time, sh_level_hold, sh_debounce;
  logic [7:0]  sh_ramp_step, sh_start_level;
  logic        sh_led_on, sh_btn_on;

  // shadow copy of the pattern state
  logic              hb_mode;
  logic [7:0]        duty_lvl;
  logic signed [8:0] ramp_delta;
  logic [1:0]        beat_phase;
  logic [TW-1:0]     level_el, beat_el, beat_wait, deb_el;
  logic              deb_busy, btn_stable, pwm_on, led_pin;

  led_out_t expected_leds[$];
  int  mismatches = 0;
  int  ticks_sent = 0;
  int  results_checked = 0;
  int  mode_toggles = 0;
  int  settings_loaded = 0;
  int  cur_debounce = 100;
  logic press_level = 1'b0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("Timeout: results stopped arriving");
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] t);
    return (t == TIMER_FULL) ? t : t + 1'b1;
  endfunction

  function automatic void reset_shadow();
    sh_on_time     = RST_ON_TIME;
    sh_rest_time   = RST_REST_TIME;
    sh_level_hold  = RST_LEVEL_HOLD;
    sh_ramp_step   = RST_RAMP_STEP;
    sh_start_level = RST_START_LEVEL;
    sh_debounce    = RST_DEBOUNCE_TICKS;
    sh_led_on      = RST_LED_ON_LEVEL;
    sh_btn_on      = RST_BUTTON_ON_LEVEL;
    hb_mode    = 1'b1;
    duty_lvl   = '0;
    ramp_delta = $signed({1'b0, sh_ramp_step});
    level_el   = '0;
    beat_phase = '0;
    beat_el    = '0;
    beat_wait  = '0;
    deb_busy   = 1'b0;
    deb_el     = '0;
    btn_stable = ~sh_btn_on;
    pwm_on     = 1'b0;
    led_pin    = ~sh_led_on;
  endfunction

  function automatic void apply_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(idx))
      REG_ON_TIME:         sh_on_time = data;
      REG_REST_TIME:       sh_rest_time = data;
      REG_LEVEL_HOLD:      sh_level_hold = data;
      REG_RAMP_STEP:       sh_ramp_step = data[7:0];
      REG_START_LEVEL:     sh_start_level = data[7:0];
      REG_DEBOUNCE_TICKS:  sh_debounce = data;
      REG_LED_ON_LEVEL:    sh_led_on = data[0];
      REG_BUTTON_ON_LEVEL: sh_btn_on = data[0];
      default: ;
    endcase
  endfunction

  // released button: LED dark, mode flips and the new pattern restarts
  function automatic void flip_mode();
    pwm_on  = 1'b0;
    led_pin = ~sh_led_on;
    hb_mode = ~hb_mode;
    mode_toggles++;
    if (hb_mode) begin
      beat_el    = '0;
      beat_phase = '0;
      beat_wait  = sh_rest_time;
    end else begin
      level_el   = TIMER_FULL;
      ramp_delta = $signed({1'b0, sh_start_level});
      duty_lvl   = '0;
    end
  endfunction

  // one millisecond tick of the pattern controller
  function automatic void advance_led_pattern(input logic btn);
    int       sum;
    led_out_t r;
    level_el = sat_inc(level_el);
    beat_el  = sat_inc(beat_el);
    deb_el   = sat_inc(deb_el);

    if (hb_mode) begin
      if (beat_el > beat_wait) begin
        led_pin = beat_phase[0] ? ~sh_led_on : sh_led_on;
        if (beat_phase == PHASE_LAST) begin
          beat_wait  = sh_rest_time;
          beat_phase = '0;
        end else begin
          beat_wait  = sh_on_time;
          beat_phase = beat_phase + 2'd1;
        end
        beat_el = '0;
      end
    end else if (level_el > sh_level_hold) begin
      sum = int'(duty_lvl) + int'(ramp_delta);
      if (sum <= 0) begin
        duty_lvl   = sh_start_level;
        ramp_delta = $signed({1'b0, sh_ramp_step});
      end else if (sum >= int'(DUTY_FULL)) begin
        duty_lvl   = 8'hFF;
        ramp_delta = -$signed({1'b0, sh_ramp_step});
      end else begin
        duty_lvl = sum[7:0];
      end
      pwm_on   = 1'b1;
      level_el = '0;
    end

    // debounce: a bounce back to the stable level keeps the running count
    if (btn != btn_stable) begin
      if (!deb_busy) begin
        deb_busy = 1'b1;
        deb_el   = '0;
      end else if (deb_el > sh_debounce) begin
        deb_busy = 1'b0;
        if (btn_stable == sh_btn_on) flip_mode();
        btn_stable = btn;
      end
    end

    r.led  = pwm_on ? 1'b0 : led_pin;
    r.pwm  = pwm_on;
    r.duty = pwm_on ? duty_lvl : 8'd0;
    r.beat = hb_mode;
    expected_leds.push_back(r);
  endfunction

  function automatic void report_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // monitor: check results, track register writes, predict accepted ticks
  always @(posedge clk) begin
    led_out_t e;
    if (rst) begin
      reset_shadow();
      expected_leds.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_leds.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual led=%0b pwm=%0b duty=%0d hb=%0b",
                   $time, led_level, pwm_active, pwm_duty, heartbeat_mode);
          mismatches++;
        end else begin
          e = expected_leds.pop_front();
          report_field("led_level", e.led, led_level);
          report_field("pwm_active", e.pwm, pwm_active);
          report_field("pwm_duty", e.duty, pwm_duty);
          report_field("heartbeat_mode", e.beat, heartbeat_mode);
          results_checked++;
        end
      end
      if (cfg_write) apply_cfg(cfg_index, cfg_data);
      if (in_valid && !in_stall) advance_led_pattern(button_level);
    end
  end

  // receiver: random stall bursts, one long hold on request, none in the tail
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // send one tick item, with an optional idle burst ahead of it
  task automatic send_tick(input logic btn);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    button_level <= btn;
    do begin
      @(posedge clk);
    end while (in_stall);
    ticks_sent++;
  endtask

  task automatic hold_level(input logic lvl, input int n);
    repeat (n) send_tick(lvl);
  endtask

  task automatic send_bits(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_tick(bits[i]);
  endtask

  // wait until every expected result is in and the block is quiet
  task automatic drain_items();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // full register load; unused upper bits of narrow registers carry noise
  task automatic load_settings(input logic [15:0] on_t, input logic [15:0] off_t,
                               input logic [15:0] lvl_p, input logic [7:0] ramp,
                               input logic [7:0] start, input logic [15:0] deb,
                               input logic led_on, input logic btn_on);
    drain_items();
    write_reg(REG_ON_TIME, on_t);
    write_reg(REG_REST_TIME, off_t);
    write_reg(REG_LEVEL_HOLD, lvl_p);
    write_reg(REG_RAMP_STEP, {8'($urandom), ramp});
    write_reg(REG_START_LEVEL, {8'($urandom), start});
    write_reg(REG_DEBOUNCE_TICKS, deb);
    write_reg(REG_LED_ON_LEVEL, {15'($urandom), led_on});
    write_reg(REG_BUTTON_ON_LEVEL, {15'($urandom), btn_on});
    cur_debounce = deb;
    press_level  = btn_on;
    settings_loaded++;
  endtask

  function automatic logic [15:0] pick_period();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return 16'($urandom_range(0, 12));
    else if (k == 7) return 16'd0;
    else if (k == 8) return 16'hFFFF;
    else return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_level();
    int k;
    k = $urandom_range(0, 5);
    if (k == 0) return 8'd1;
    else if (k == 1) return 8'd255;
    else return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [15:0] pick_debounce();
    int k;
    k = $urandom_range(0, 9);
    if (k < 8) return 16'($urandom_range(0, 6));
    else if (k == 8) return 16'hFFFF;
    else return 16'($urandom_range(7, 40));
  endfunction

  // press/release gestures with bounce noise, some cut short, some pure noise
  task automatic run_gestures(input int n_ticks);
    int stop_at, kind, span, len;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      span = (cur_debounce > 20) ? 20 : cur_debounce;
      if (kind <= 6) begin
        repeat ($urandom_range(0, 2)) send_tick(1'($urandom_range(0, 1)));
        len = span + 2 + $urandom_range(0, 4);
        hold_level(press_level, len);
        repeat ($urandom_range(0, 2)) send_tick(1'($urandom_range(0, 1)));
        hold_level(~press_level, len);
      end else if (kind <= 8) begin
        hold_level(press_level, $urandom_range(1, span + 1));
        hold_level(~press_level, $urandom_range(1, span + 1));
      end else begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // defaults after reset: first heartbeat phase fires at once, a bounce starts debounce
  task automatic test_reset_defaults();
    send_bits(32'b1101, 4);
  endtask

  // extremes: full-scale ramp, zero periods, bounce-back during debounce,
  // pulse with a level period equal to the saturated count
  task automatic test_directed();
    load_settings(16'd1, 16'd3, 16'd0, 8'd255, 8'd255, 16'd1, 1'b1, 1'b1);
    send_bits(32'b11000000101000000000, 20);
    load_settings(16'd0, 16'd0, 16'hFFFF, 8'd1, 8'd1, 16'd0, 1'b0, 1'b0);
    send_bits(32'b1110011, 7);
  endtask

  task automatic test_random_patterns();
    for (int p = 0; p < 10; p++) begin
      if (p == 0)
        load_settings(16'd0, 16'hFFFF, 16'd0, 8'd1, 8'd1, 16'd0, 1'b0, 1'b1);
      else if (p == 1)
        load_settings(16'hFFFF, 16'd0, 16'd2, 8'd255, 8'd255, 16'd6, 1'b1, 1'b0);
      else
        load_settings(pick_period(), pick_period(), pick_period(), pick_level(),
                      pick_level(), pick_debounce(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      run_gestures(100);
    end
  endtask

  // receiver holds off long while ticks keep coming, so the block stalls its input
  task automatic test_backpressure();
    load_settings(16'd2, 16'd5, 16'd1, 8'd40, 8'd20, 16'd1, 1'b0, 1'b0);
    hold_req = 1'b1;
    run_gestures(30);
  endtask

  // tail without any idling on either side
  task automatic test_steady_tail();
    load_settings(16'd3, 16'd7, 16'd0, 8'd60, 8'd30, 16'd2, 1'b1, 1'b1);
    quiet = 1'b1;
    run_gestures(100);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_patterns();
    test_backpressure();
    test_steady_tail();
    drain_items();
    $display("Covered %0d ticks under %0d register settings, %0d results checked.",
             ticks_sent, settings_loaded, results_checked);
    $display("Mode toggled %0d times; long output hold with input backpressure included.",
             mode_toggles);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== led_heartbeat_breathing_controller.f =====
hdl/lhb_pkg.sv
hdl/led_heartbeat_breathing_controller.sv
tb/led_heartbeat_breathing_controller_tb.sv
